// ----- design/sbh_pkg.sv -----
// Shared types, constants and round functions for the SHA-256 byte stream hasher.
package sbh_pkg;

	// Controller states, one-hot
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_PAD   = 4'b0010,
		ST_ROUND = 4'b0100,
		ST_FOLD  = 4'b1000
	} state_t;

	// Source of the byte shifted into the block buffer
	typedef enum logic [1:0] {
		SEL_DATA = 2'd0,
		SEL_PAD  = 2'd1,
		SEL_ZERO = 2'd2,
		SEL_LEN  = 2'd3
	} byte_sel_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic      shift_en;
		byte_sel_t byte_sel;
		logic      count_en;
		logic      work_load;
		logic      round_en;
		logic [5:0] rnd;
		logic      fold_en;
		logic      digest_load;
		logic      out_shift;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic [5:0] fill;
	} status_t;

	localparam logic [7:0] PAD_BYTE   = 8'h80;
	localparam logic [5:0] LEN_OFFSET = 6'd56;
	localparam logic [5:0] LAST_POS   = 6'd63;
	localparam logic [5:0] LAST_ROUND = 6'd63;

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
		ror32 = (x >> n) | (x << (32 - n));
	endfunction

	// Schedule sigma functions
	function automatic logic [31:0] sig0(input logic [31:0] x);
		sig0 = ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] sig1(input logic [31:0] x);
		sig1 = ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
	endfunction

	// Round Sigma functions
	function automatic logic [31:0] big0(input logic [31:0] x);
		big0 = ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
	endfunction

	function automatic logic [31:0] big1(input logic [31:0] x);
		big1 = ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
	endfunction

endpackage

// ----- design/sbh_ctrl.sv -----
// Controller state machine: byte intake, padding sequence, rounds, fold and digest drain.
module sbh_ctrl import sbh_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic     byte_valid,
	input  logic     last_byte,
	output logic     out_valid,
	input  logic     out_ready,
	output logic [2:0] word_index,
	output logic     last_word,
	input  status_t  status,
	output cmd_t     cmd
);

	state_t     state_q, state_d;
	logic [5:0] rnd_q;
	logic       first_q, first_d;     // next pad byte is the 0x80 marker
	logic       final_q, final_d;     // current pad block carries the length
	logic       padding_q, padding_d; // padding of the message in progress
	logic       finish_q, finish_d;   // last item came with a full block
	logic       out_valid_q;
	logic [2:0] out_idx_q;
	logic       in_fire;

	assign in_ready   = (state_q == ST_IDLE);
	assign in_fire    = in_valid & in_ready;
	assign out_valid  = out_valid_q;
	assign word_index = out_idx_q;
	assign last_word  = (out_idx_q == 3'd7);

	// Next state and datapath commands
	always_comb begin
		state_d   = state_q;
		first_d   = first_q;
		final_d   = final_q;
		padding_d = padding_q;
		finish_d  = finish_q;
		cmd             = '0;
		cmd.byte_sel    = SEL_DATA;
		cmd.rnd         = rnd_q;
		cmd.out_shift   = out_valid_q & out_ready;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (byte_valid) begin
						cmd.shift_en = 1'b1;
						cmd.count_en = 1'b1;
					end
					if (byte_valid && status.fill == LAST_POS) begin
						cmd.work_load = 1'b1;
						finish_d      = last_byte;
						state_d       = ST_ROUND;
					end else if (last_byte) begin
						first_d   = 1'b1;
						padding_d = 1'b1;
						state_d   = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				cmd.shift_en = 1'b1;
				if (first_q) begin
					cmd.byte_sel = SEL_PAD;
					final_d      = (status.fill < LEN_OFFSET);
				end else if (final_q && status.fill >= LEN_OFFSET) begin
					cmd.byte_sel = SEL_LEN;
				end else begin
					cmd.byte_sel = SEL_ZERO;
				end
				first_d = 1'b0;
				if (status.fill == LAST_POS) begin
					cmd.work_load = 1'b1;
					state_d       = ST_ROUND;
				end
			end
			ST_ROUND: begin
				cmd.round_en = 1'b1;
				if (rnd_q == LAST_ROUND) begin
					state_d = ST_FOLD;
				end
			end
			ST_FOLD: begin
				if (padding_q && final_q) begin
					// hold the digest until the previous one has drained
					if (!out_valid_q) begin
						cmd.digest_load = 1'b1;
						padding_d       = 1'b0;
						final_d         = 1'b0;
						state_d         = ST_IDLE;
					end
				end else if (padding_q) begin
					cmd.fold_en = 1'b1;
					final_d     = 1'b1;
					state_d     = ST_PAD;
				end else if (finish_q) begin
					cmd.fold_en = 1'b1;
					finish_d    = 1'b0;
					padding_d   = 1'b1;
					first_d     = 1'b1;
					state_d     = ST_PAD;
				end else begin
					cmd.fold_en = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rnd_q     <= '0;
			first_q   <= 1'b0;
			final_q   <= 1'b0;
			padding_q <= 1'b0;
			finish_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			first_q   <= first_d;
			final_q   <= final_d;
			padding_q <= padding_d;
			finish_q  <= finish_d;
			if (cmd.round_en) begin
				rnd_q <= rnd_q + 6'd1;
			end
		end
	end

	// Digest drain: valid flag and word index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_idx_q   <= '0;
		end else if (cmd.digest_load) begin
			out_valid_q <= 1'b1;
			out_idx_q   <= '0;
		end else if (cmd.out_shift) begin
			out_idx_q <= out_idx_q + 3'd1;
			if (out_idx_q == 3'd7) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The round counter wraps back to zero exactly as the fold begins
	a_round_to_fold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && rnd_q == LAST_ROUND) |=> (state_q == ST_FOLD && rnd_q == 6'd0))
		else $error("rounds did not end in fold");

	// A new digest never overwrites one still draining
	a_no_digest_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.digest_load |-> !out_valid_q)
		else $error("digest loaded while output busy");

	// Back in idle, no padding flags are left behind
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!padding_q && !first_q && !finish_q && !final_q))
		else $error("padding flags set in idle");

	// A compression only starts with the buffer full
	a_full_block: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.work_load |-> (status.fill == LAST_POS && cmd.shift_en))
		else $error("compression started on partial block");

endmodule

// ----- design/sbh_dp.sv -----
// Datapath: block buffer and schedule window, counters, round logic, chaining state, digest buffer.
module sbh_dp import sbh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  data_byte,
	input  cmd_t        cmd,
	output status_t     status,
	output logic [31:0] digest_word
);

	logic [511:0] blk_q;          // 64-byte buffer, doubles as schedule window
	logic [5:0]   fill_q;
	logic [60:0]  msg_q;
	logic [31:0]  chain_q [8];
	logic [31:0]  work_q [8];
	logic [31:0]  dg_q [8];

	logic [7:0]   byte_in;
	logic [63:0]  bit_len;
	logic [2:0]   len_idx;
	logic [31:0]  w0, w1, w9, w14, w_new;
	logic [31:0]  t1, t2;
	logic [31:0]  ch, maj;

	assign status.fill = fill_q;
	assign digest_word = dg_q[0];

	// Byte source for the buffer
	assign bit_len = {msg_q, 3'b000};
	assign len_idx = 3'd7 - fill_q[2:0];
	always_comb begin
		case (cmd.byte_sel)
			SEL_DATA: byte_in = data_byte;
			SEL_PAD:  byte_in = PAD_BYTE;
			SEL_LEN:  byte_in = bit_len[{len_idx, 3'b000} +: 8];
			default:  byte_in = 8'h00;
		endcase
	end

	// Schedule: oldest word sits at the top of the buffer
	assign w0    = blk_q[511:480];
	assign w1    = blk_q[479:448];
	assign w9    = blk_q[223:192];
	assign w14   = blk_q[63:32];
	assign w_new = w0 + sig0(w1) + w9 + sig1(w14);

	// One compression round
	assign ch  = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
	assign maj = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
	assign t1  = work_q[7] + big1(work_q[4]) + ch + ROUND_K[cmd.rnd] + w0;
	assign t2  = big0(work_q[0]) + maj;

	// Buffer: byte shift on intake and padding, word shift during rounds
	always_ff @(posedge clk) begin
		if (cmd.shift_en) begin
			blk_q <= {blk_q[503:0], byte_in};
		end else if (cmd.round_en) begin
			blk_q <= {blk_q[479:0], w_new};
		end
	end

	// Fill and message length counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			msg_q  <= '0;
		end else begin
			if (cmd.shift_en) begin
				fill_q <= fill_q + 6'd1;
			end
			if (cmd.digest_load) begin
				msg_q <= '0;
			end else if (cmd.count_en) begin
				msg_q <= msg_q + 61'd1;
			end
		end
	end

	// Working variables
	always_ff @(posedge clk) begin
		if (cmd.work_load) begin
			for (int i = 0; i < 8; i++) begin
				work_q[i] <= chain_q[i];
			end
		end else if (cmd.round_en) begin
			work_q[0] <= t1 + t2;
			work_q[1] <= work_q[0];
			work_q[2] <= work_q[1];
			work_q[3] <= work_q[2];
			work_q[4] <= work_q[3] + t1;
			work_q[5] <= work_q[4];
			work_q[6] <= work_q[5];
			work_q[7] <= work_q[6];
		end
	end

	// Chaining state: fold after each block but the last, back to the initial values on digest load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= INIT_H[i];
			end
		end else if (cmd.digest_load) begin
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= INIT_H[i];
			end
		end else if (cmd.fold_en) begin
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= chain_q[i] + work_q[i];
			end
		end
	end

	// Digest buffer, shifts one word per delivered item
	always_ff @(posedge clk) begin
		if (cmd.digest_load) begin
			for (int i = 0; i < 8; i++) begin
				dg_q[i] <= chain_q[i] + work_q[i];
			end
		end else if (cmd.out_shift) begin
			for (int i = 0; i < 7; i++) begin
				dg_q[i] <= dg_q[i + 1];
			end
			dg_q[7] <= dg_q[7];
		end
	end

endmodule

// ----- design/sha256_byte_stream_hasher_unit.sv -----
// Top level of the SHA-256 byte stream hasher: controller plus datapath.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------
//  in      | input     | in_valid/in_ready  | data_byte[7:0], byte_valid, last_byte
//  out     | output    | out_valid/out_ready| digest_word[31:0], word_index[2:0], last_word
//
// A byte item is taken while in_ready is high; the 64th byte of a block starts the rounds of
// the single shared round unit and then the fold, with in_ready low.
// A last item adds padding, one byte per cycle to the end of the block, then a compression;
// a second padding pass and compression follow when the length does not fit.
// The digest drains as eight items while the next message is taken; a later digest waits
// in the fold state until the previous one is gone. Reset is asynchronous.
module sha256_byte_stream_hasher_unit import sbh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        byte_valid,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	cmd_t    cmd;
	status_t status;

	sbh_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.byte_valid (byte_valid),
		.last_byte  (last_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.word_index (word_index),
		.last_word  (last_word),
		.status     (status),
		.cmd        (cmd)
	);

	sbh_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_byte   (data_byte),
		.cmd         (cmd),
		.status      (status),
		.digest_word (digest_word)
	);

endmodule

// ----- bench/sha256_byte_stream_hasher_unit_tb.sv -----
// Self-checking testbench for the SHA-256 byte stream hasher: random bytes in, digests checked.
module sha256_byte_stream_hasher_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int        QUIET_LIMIT = 8000;   // cycles without any item moving
	localparam int        HOLD_AT     = 200;    // input items taken before the long stall
	localparam int        HOLD_LEN    = 1500;   // receiver stall length in cycles
	localparam int        SETTLE      = 300;    // cycles allowed after the last digest
	localparam int        FEED_ITEMS  = 440;    // queue is filled up to about this many items
	localparam bit [7:0]  PAD_MARK    = 8'h80;
	localparam int        LEN_POS     = 56;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        byte_valid = 1'b0;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	sha256_byte_stream_hasher_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.byte_valid(byte_valid),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.digest_word(digest_word),
		.word_index(word_index),
		.last_word(last_word)
	);

	// One input item and one digest word
	typedef struct {
		bit [7:0] data;
		bit       valid;
		bit       last;
		bit       drain;   // hold this item back until all digests are out
	} feed_item_t;

	typedef struct {
		bit [31:0] word;
		bit [2:0]  idx;
		bit        last;
	} digest_word_t;

	feed_item_t   pending[$];
	digest_word_t digest_q[$];

	int items_taken = 0;
	int words_owed = 0;
	int words_seen = 0;
	int errors = 0;
	int tx_wait = 0;
	int rx_wait = 0;
	int quiet = 0;
	bit tx_burst = 1'b0;
	bit rx_burst = 1'b0;
	bit hold_done = 1'b0;

	// Shadow hash state
	bit [31:0] chain[8];
	bit [7:0]  blk[64];
	bit [5:0]  fill;
	bit [60:0] nbytes;

	bit [31:0] round_const[64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	bit [31:0] start_chain[8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic bit [31:0] rotr(bit [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void sha_restart();
		for (int i = 0; i < 8; i++) chain[i] = start_chain[i];
		for (int i = 0; i < 64; i++) blk[i] = 8'h00;
		fill = '0;
		nbytes = '0;
	endfunction

	// 64-round compression of the block buffer into the chaining words
	function automatic void compress_block();
		bit [31:0] w[64];
		bit [31:0] v[8];
		bit [31:0] s0, s1, t1, t2, ch, maj;
		for (int i = 0; i < 16; i++)
			w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
		for (int i = 16; i < 64; i++) begin
			s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = w[i-16] + s0 + w[i-7] + s1;
		end
		for (int i = 0; i < 8; i++) v[i] = chain[i];
		for (int i = 0; i < 64; i++) begin
			ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
			t1  = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) + ch
				+ round_const[i] + w[i];
			maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
			t2  = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) + maj;
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
	endfunction

	// Fold one accepted item into the shadow state; returns digest words queued
	function automatic int absorb_item(bit [7:0] d, bit v, bit l);
		bit [63:0]    bitlen;
		int           pos;
		digest_word_t dw;
		if (v) begin
			blk[fill] = d;
			fill++;
			nbytes++;
			if (fill == 0) compress_block();
		end
		if (!l) return 0;
		bitlen = {nbytes, 3'b000};
		pos = fill;
		blk[pos] = PAD_MARK;
		pos++;
		// No room for the length: close this block and pad a fresh one
		if (pos > LEN_POS) begin
			for (int i = pos; i < 64; i++) blk[i] = 8'h00;
			compress_block();
			pos = 0;
		end
		for (int i = pos; i < LEN_POS; i++) blk[i] = 8'h00;
		for (int i = 0; i < 8; i++) blk[63-i] = bitlen[8*i +: 8];
		compress_block();
		for (int i = 0; i < 8; i++) begin
			dw.word = chain[i];
			dw.idx  = i[2:0];
			dw.last = (i == 7);
			digest_q.push_back(dw);
		end
		sha_restart();
		return 8;
	endfunction

	task automatic report(string field, bit [31:0] want, bit [31:0] got);
		errors++;
		$error("%s: expected %0h, got %0h", field, want, got);
	endtask

	task automatic add_item(bit [7:0] d, bit v, bit l, bit drain);
		feed_item_t it;
		it.data  = d;
		it.valid = v;
		it.last  = l;
		it.drain = drain;
		pending.push_back(it);
	endtask

	// Message of len random bytes; split_last closes it with a byte-less item
	task automatic queue_message(int len, bit split_last, bit drain);
		for (int i = 0; i < len; i++) begin
			if (i > 0 && $urandom_range(0, 9) == 0)
				add_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
			add_item(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !split_last,
				drain && (i == 0));
		end
		if (len == 0 || split_last)
			add_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, drain && (len == 0));
	endtask

	always #5 clk = ~clk;

	// Input driver
	always @(posedge clk or negedge arst_n) begin : feed_side
		feed_item_t nxt;
		bit         free;
		int         gap;
		int         bump;
		if (!arst_n) begin
			in_valid   <= 1'b0;
			data_byte  <= 8'h00;
			byte_valid <= 1'b0;
			last_byte  <= 1'b0;
			tx_wait    <= 0;
		end else begin
			free = !in_valid;
			gap  = tx_wait;
			bump = 0;
			if (in_valid && in_ready) begin
				bump = absorb_item(data_byte, byte_valid, last_byte);
				words_owed  <= words_owed + bump;
				items_taken <= items_taken + 1;
				free = 1'b1;
				if ($urandom_range(0, 49) == 0) tx_burst = !tx_burst;
				gap = tx_burst ? 0 : $urandom_range(0, 4);
			end
			if (free) begin
				if (gap != 0) begin
					tx_wait  <= gap - 1;
					in_valid <= 1'b0;
				end else if (pending.size() != 0 &&
					(!pending[0].drain || words_owed + bump == words_seen)) begin
					nxt = pending.pop_front();
					in_valid   <= 1'b1;
					data_byte  <= nxt.data;
					byte_valid <= nxt.valid;
					last_byte  <= nxt.last;
					tx_wait    <= 0;
				end else begin
					in_valid <= 1'b0;
					tx_wait  <= 0;
				end
			end
		end
	end

	// Digest monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin : digest_side
		digest_word_t want;
		int           stall;
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_wait   <= 0;
		end else begin
			stall = rx_wait;
			if (out_valid && out_ready) begin
				words_seen <= words_seen + 1;
				if (digest_q.size() == 0) begin
					report("unexpected digest_word", 32'h0, digest_word);
				end else begin
					want = digest_q.pop_front();
					if (digest_word !== want.word) report("digest_word", want.word, digest_word);
					if (word_index !== want.idx)
						report("word_index", 32'(want.idx), 32'(word_index));
					if (last_word !== want.last)
						report("last_word", 32'(want.last), 32'(last_word));
				end
				if ($urandom_range(0, 49) == 0) rx_burst = !rx_burst;
				stall = rx_burst ? 0 : $urandom_range(0, 4);
			end
			// One long stall so the hasher backs up into its input
			if (!hold_done && items_taken >= HOLD_AT) begin
				hold_done <= 1'b1;
				stall = HOLD_LEN;
			end
			if (stall != 0) begin
				out_ready <= 1'b0;
				rx_wait   <= stall - 1;
			end else begin
				out_ready <= 1'b1;
				rx_wait   <= 0;
			end
		end
	end

	// Watchdog on handshake activity
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet <= 0;
			end else begin
				quiet <= quiet + 1;
				if (quiet >= QUIET_LIMIT) begin
					$display("sha256_byte_stream_hasher_unit_tb: done, errors");
					$finish;
				end
			end
		end
	end

	// Stimulus and end of run
	initial begin : run
		int  len;
		int  pick;
		bit  split;
		bit  first;
		int  edge_lens[10];
		edge_lens = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
		sha_restart();

		// Directed: idle items, empty message, single bytes at the extremes, then abc
		add_item(8'hff, 1'b0, 1'b0, 1'b0);
		add_item(8'h00, 1'b0, 1'b0, 1'b0);
		add_item(8'ha5, 1'b0, 1'b1, 1'b0);
		add_item(8'h00, 1'b1, 1'b1, 1'b0);
		add_item(8'hff, 1'b1, 1'b1, 1'b0);
		add_item(8'h61, 1'b1, 1'b0, 1'b0);
		add_item(8'h62, 1'b1, 1'b0, 1'b0);
		add_item(8'h63, 1'b1, 1'b1, 1'b0);
		// Closing item without a byte
		add_item(8'h55, 1'b1, 1'b0, 1'b0);
		add_item(8'haa, 1'b1, 1'b0, 1'b0);
		add_item(8'h3c, 1'b0, 1'b1, 1'b0);
		// Idle item inside a message
		add_item(8'h01, 1'b1, 1'b0, 1'b0);
		add_item(8'hc3, 1'b0, 1'b0, 1'b0);
		add_item(8'h80, 1'b1, 1'b0, 1'b0);
		add_item(8'h7f, 1'b1, 1'b1, 1'b0);

		// Random messages, mostly short, some around the padding boundaries
		first = 1'b1;
		while (pending.size() < FEED_ITEMS) begin
			pick = $urandom_range(0, 9);
			if (pick < 5)
				len = $urandom_range(0, 20);
			else if (pick < 8)
				len = edge_lens[$urandom_range(0, 9)];
			else
				len = $urandom_range(0, 140);
			split = (len == 0) || ($urandom_range(0, 2) == 0);
			queue_message(len, split, first || ($urandom_range(0, 11) == 0));
			first = 1'b0;
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending.size() == 0 && !in_valid);
		wait (digest_q.size() == 0);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("sha256_byte_stream_hasher_unit_tb: done, clean");
		else
			$display("sha256_byte_stream_hasher_unit_tb: done, errors");
		$finish;
	end

endmodule
